/* rtl/lvxc_pkg.sv */
package lvxc_pkg;

  localparam int unsigned KEY_MAX     = 16;
  localparam int unsigned KEY_IDX_W   = 4;
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_DIR      = 2'd3
  } reg_idx_e;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_e;

  typedef struct packed {
    logic [KEY_MAX-1:0][7:0] key;
    logic [KEY_LEN_W-1:0]    key_len;
    dir_e                    dir;
  } cfg_t;

  // one byte with its key byte and key residues, waiting for the cipher datapath
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    dir_e       dir;
    logic [7:0] key;
    logic [4:0] key_m26;
    logic [4:0] key_m10;
    logic [4:0] key_m15;
  } entry_t;

  // k mod span by reciprocal multiply, exact for any 8-bit k with these constants
  function automatic logic [4:0] key_mod(logic [7:0] k, logic [4:0] span, logic [12:0] recip);
    logic [20:0] prod;
    logic [4:0]  quo;
    logic [9:0]  qs;
    prod = 21'(k) * 21'(recip);
    quo  = prod[20:16];
    qs   = 10'(quo) * 10'(span);
    return 5'(10'(k) - qs);
  endfunction

endpackage

/* rtl/lvxc_front.sv */
module lvxc_front import lvxc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  input  logic       full_i,
  input  cfg_t       cfg_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);

  logic [KEY_IDX_W-1:0] pos_q, pos_d;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_LEN_W-1:0] idx_inc;
  logic [7:0]           key;
  logic                 accept;

  assign accept = push_i & ~full_i;

  always_comb begin
    if (cfg_i.key_len == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (cfg_i.key_len > KEY_LEN_W'(KEY_MAX)) begin
      len_eff = KEY_LEN_W'(KEY_MAX);
    end else begin
      len_eff = cfg_i.key_len;
    end
  end

  always_comb begin
    idx = pos_q;
    // a stale position past a shortened key falls back to key byte 0
    if (KEY_LEN_W'(pos_q) >= len_eff) begin
      idx = '0;
    end
    idx_inc = KEY_LEN_W'(idx) + KEY_LEN_W'(1);
    if (end_of_message_i || idx_inc >= len_eff) begin
      pos_d = '0;
    end else begin
      pos_d = idx_inc[KEY_IDX_W-1:0];
    end
  end

  assign key = cfg_i.key[idx];

  always_comb begin
    q_entry_o.data    = data_byte_i;
    q_entry_o.last    = end_of_message_i;
    q_entry_o.dir     = cfg_i.dir;
    q_entry_o.key     = key;
    q_entry_o.key_m26 = key_mod(key, 5'd26, 13'd2521);
    q_entry_o.key_m10 = key_mod(key, 5'd10, 13'd6554);
    q_entry_o.key_m15 = key_mod(key, 5'd15, 13'd4370);
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

endmodule

/* rtl/lvxc_queue.sv */
module lvxc_queue import lvxc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   valid_o
);

  entry_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(logic [QUEUE_PTR_W-1:0] p);
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/lvxc_back.sv */
module lvxc_back import lvxc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       take;
  logic [7:0] result;

  // rotate b within its class by s (already reduced mod span)
  function automatic logic [7:0] class_shift(logic [7:0] b, entry_t e, logic enc);
    logic [7:0] base;
    logic [5:0] span;
    logic [5:0] s;
    logic [5:0] off;
    logic [5:0] t;
    logic       hit;
    hit  = 1'b1;
    base = 8'd0;
    span = 6'd1;
    s    = 6'd0;
    if (b >= 8'd65 && b <= 8'd90) begin
      base = 8'd65; span = 6'd26; s = 6'(e.key_m26);
    end else if (b >= 8'd97 && b <= 8'd122) begin
      base = 8'd97; span = 6'd26; s = 6'(e.key_m26);
    end else if (b >= 8'd48 && b <= 8'd57) begin
      base = 8'd48; span = 6'd10; s = 6'(e.key_m10);
    end else if (b >= 8'd33 && b <= 8'd47) begin
      base = 8'd33; span = 6'd15; s = 6'(e.key_m15);
    end else begin
      hit = 1'b0;
    end
    off = 6'(b - base);
    if (enc) begin
      t = off + s;
      if (t >= span) begin
        t = t - span;
      end
    end else if (off < s) begin
      t = off + span - s;
    end else begin
      t = off - s;
    end
    return hit ? (base + 8'(t)) : b;
  endfunction

  always_comb begin
    logic [7:0] mid;
    if (q_entry_i.dir == DIR_ENCRYPT) begin
      mid    = class_shift(q_entry_i.data, q_entry_i, 1'b1) + q_entry_i.key;
      result = mid ^ q_entry_i.key;
    end else begin
      mid    = (q_entry_i.data ^ q_entry_i.key) - q_entry_i.key;
      result = class_shift(mid, q_entry_i, 1'b0);
    end
  end

  // load the output register when it is free or being drained
  assign take    = q_valid_i & (~out_valid_q | pop_i);
  assign q_pop_o = take;

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= result;
      out_last_q <= q_entry_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o    = ~out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule

/* rtl/layered_vigenere_xor_byte_cipher_top.sv */
// path: an accepted byte passes through the queue into the output register on the result ports
// throughput: one byte per cycle through front, queue and output register while pop is high
// the two-entry queue lets the front keep taking bytes while the result side stalls, until full
// reset: async active low; key position, queue and output valid clear, key registers
// clear to zero, key length resets to 1 and direction to encrypt
module layered_vigenere_xor_byte_cipher_top import lvxc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input side
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_message_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_DATA_W-1:0] key_low_q;
  logic [CFG_DATA_W-1:0] key_high_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  dir_e                  dir_q;
  reg_idx_e              reg_idx;
  logic                  cfg_wr;
  cfg_t                  cfg;

  logic                  q_push;
  entry_t                q_in;
  logic                  q_full;
  logic                  q_pop;
  entry_t                q_out;
  logic                  q_valid;

  // registers sit on 8-byte boundaries, low address bits are ignored
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KEY_LEN_W'(1);
      dir_q      <= DIR_ENCRYPT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LEN:  key_len_q  <= pwdata[KEY_LEN_W-1:0];
        REG_DIR:      dir_q      <= dir_e'(pwdata[0]);
        default:      ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LEN:  prdata = CFG_DATA_W'(key_len_q);
      REG_DIR:      prdata = CFG_DATA_W'(dir_q);
      default:      prdata = '0;
    endcase
  end

  // key byte 0 in the low bits of the low register
  always_comb begin
    cfg.key     = {key_high_q, key_low_q};
    cfg.key_len = key_len_q;
    cfg.dir     = dir_q;
  end

  // front: transfer acceptance, key position tracking and key residue computation
  lvxc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .full_i           (q_full),
    .cfg_i            (cfg),
    .q_push_o         (q_push),
    .q_entry_o        (q_in)
  );

  // decoupling queue between front and back
  lvxc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .valid_o (q_valid)
  );

  // back: shift / add / xor chain (xor / subtract / shift to decrypt) into the output register
  lvxc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_out),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  assign full = q_full;

endmodule

/* sim/tb_layered_vigenere_xor_byte_cipher_top.sv */
module tb_layered_vigenere_xor_byte_cipher_top import lvxc_pkg::*; ();

  // clock, reset and block ports
  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [7:0]            data_byte_i;
  logic                  end_of_message_i;
  logic                  empty;
  logic                  pop;
  logic [7:0]            out_byte_o;
  logic                  out_last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  layered_vigenere_xor_byte_cipher_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .out_last_o       (out_last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // one expected output transfer
  typedef struct {
    logic [7:0] text;
    logic       last;
  } cipher_out_t;

  // directed plan: either a register write or a byte transfer
  typedef enum {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    reg_idx_e   reg_sel;
    logic [63:0] value;
    logic [7:0] text;
    logic       last;
    bit         fixed;     // expected byte typed in below
    logic [7:0] fixed_text;
  } plan_row_t;

  cipher_out_t pending_text_q[$];
  plan_row_t   directed_plan[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // shadow copy of the configuration and the key position
  logic [63:0] key_lo_shadow;
  logic [63:0] key_hi_shadow;
  logic [4:0]  key_len_shadow;
  dir_e        dir_shadow;
  logic [3:0]  key_pos_shadow;

  // result checker state
  cipher_out_t want;

  // 4 time unit clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // rotate a byte inside its character class, forward to encrypt, backward to decrypt
  function automatic logic [7:0] class_rotate(logic [7:0] b, logic [7:0] k, dir_e d);
    int unsigned base;
    int unsigned span;
    int unsigned s;
    if (b >= 8'd65 && b < 8'd91) begin
      base = 65; span = 26;
    end else if (b >= 8'd97 && b < 8'd123) begin
      base = 97; span = 26;
    end else if (b >= 8'd48 && b < 8'd58) begin
      base = 48; span = 10;
    end else if (b >= 8'd33 && b < 8'd48) begin
      base = 33; span = 15;
    end else begin
      return b;
    end
    s = int'(k) % span;
    if (d == DIR_DECRYPT) s = span - s;
    return 8'(((int'(b) - base + s) % span) + base);
  endfunction

  // full three-layer transform of one byte under one key byte
  function automatic logic [7:0] layered_cipher(logic [7:0] b, logic [7:0] k, dir_e d);
    logic [7:0] r;
    if (d == DIR_ENCRYPT) begin
      r = class_rotate(b, k, DIR_ENCRYPT);
      r = r + k;
      r = r ^ k;
    end else begin
      r = b ^ k;
      r = r - k;
      r = class_rotate(r, k, DIR_DECRYPT);
    end
    return r;
  endfunction

  // pick the key byte at the current position, transform, then move the position on
  task automatic cipher_next(input logic [7:0] b, input logic l, output cipher_out_t res);
    logic [127:0] key_bank;
    int unsigned  len;
    int unsigned  idx;
    key_bank = {key_hi_shadow, key_lo_shadow};
    len = key_len_shadow;
    if (len == 0) len = 1;
    if (len > ((KEY_MAX < 16) ? KEY_MAX : 16)) len = (KEY_MAX < 16) ? KEY_MAX : 16;
    idx = key_pos_shadow;
    // position left past a shortened key falls back to key byte 0
    if (idx >= len) idx = 0;
    res.text = layered_cipher(b, key_bank[idx*8 +: 8], dir_shadow);
    res.last = l;
    if (l) key_pos_shadow = '0;
    else if (idx + 1 >= len) key_pos_shadow = '0;
    else key_pos_shadow = 4'(idx + 1);
  endtask

  // one byte transfer on the input side, with random idle cycles ahead of it
  task automatic send_text(input logic [7:0] b, input logic l, input bit fixed,
                           input logic [7:0] fixed_text);
    cipher_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    cipher_next(b, l, res);
    if (fixed) res.text = fixed_text;
    pending_text_q.push_back(res);
  endtask

  // register write, only once every expected byte has come out
  task automatic write_reg(input reg_idx_e r, input logic [63:0] v);
    push <= 1'b0;
    while (pending_text_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({r, 3'b000});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_KEY_LOW:  key_lo_shadow = v;
      REG_KEY_HIGH: key_hi_shadow = v;
      REG_KEY_LEN:  key_len_shadow = v[4:0];
      REG_DIR:      dir_shadow = dir_e'(v[0]);
      default: ;
    endcase
  endtask

  function automatic void plan_byte(logic [7:0] b, logic l, bit fixed, logic [7:0] fixed_text);
    plan_row_t row;
    row.kind = ROW_BYTE;
    row.reg_sel = REG_KEY_LOW;
    row.value = '0;
    row.text = b;
    row.last = l;
    row.fixed = fixed;
    row.fixed_text = fixed_text;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_cfg(reg_idx_e r, logic [63:0] v);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.reg_sel = r;
    row.value = v;
    row.text = '0;
    row.last = 1'b0;
    row.fixed = 1'b0;
    row.fixed_text = '0;
    directed_plan.push_back(row);
  endfunction

  // result side: random stalls on pop
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every output transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_text_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected output transfer: expected none, got byte %02h last %0b",
                 $time, out_byte_o, out_last_o);
      end else begin
        want = pending_text_q.pop_front();
        if (out_byte_o !== want.text) begin
          error_count++;
          $display("%0t: out_byte mismatch: expected %02h, got %02h",
                   $time, want.text, out_byte_o);
        end
        if (out_last_o !== want.last) begin
          error_count++;
          $display("%0t: out_last mismatch: expected %0b, got %0b",
                   $time, want.last, out_last_o);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [63:0] kv;
    logic [4:0]  len_v;
    logic [7:0]  b;
    int unsigned sel;
    push             = 1'b0;
    data_byte_i      = '0;
    end_of_message_i = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    error_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    key_lo_shadow    = '0;
    key_hi_shadow    = '0;
    key_len_shadow   = 5'd1;
    dir_shadow       = DIR_ENCRYPT;
    key_pos_shadow   = '0;
    rst_ni           = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key is all zero, so every layer is the identity
    plan_byte(8'h00, 1'b0, 1'b1, 8'h00);
    plan_byte(8'hff, 1'b0, 1'b1, 8'hff);
    plan_byte(8'h41, 1'b0, 1'b1, 8'h41);
    plan_byte(8'h5a, 1'b0, 1'b1, 8'h5a);
    plan_byte(8'h61, 1'b0, 1'b1, 8'h61);
    plan_byte(8'h7a, 1'b0, 1'b1, 8'h7a);
    plan_byte(8'h30, 1'b0, 1'b1, 8'h30);
    plan_byte(8'h39, 1'b0, 1'b1, 8'h39);
    plan_byte(8'h21, 1'b0, 1'b1, 8'h21);
    plan_byte(8'h2f, 1'b1, 1'b1, 8'h2f);
    // zero key in the decrypt chain is still the identity
    plan_cfg(REG_DIR, 64'(DIR_DECRYPT));
    plan_byte(8'h7a, 1'b0, 1'b1, 8'h7a);
    plan_byte(8'h2f, 1'b1, 1'b1, 8'h2f);
    // all-ones key, zero key length taken as one byte
    plan_cfg(REG_KEY_LOW, '1);
    plan_cfg(REG_KEY_HIGH, '1);
    plan_cfg(REG_KEY_LEN, 64'd0);
    plan_byte(8'h41, 1'b0, 1'b0, 8'h00);
    plan_byte(8'h7a, 1'b1, 1'b0, 8'h00);
    // key length above the limit saturates to sixteen
    plan_cfg(REG_DIR, 64'(DIR_ENCRYPT));
    plan_cfg(REG_KEY_LOW, 64'h8f7e_6d5c_4b3a_2918);
    plan_cfg(REG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    plan_cfg(REG_KEY_LEN, 64'd31);
    plan_byte(8'h39, 1'b0, 1'b0, 8'h00);
    plan_byte(8'h21, 1'b0, 1'b0, 8'h00);
    plan_byte(8'h5a, 1'b0, 1'b0, 8'h00);
    plan_byte(8'hc3, 1'b0, 1'b0, 8'h00);
    plan_byte(8'h61, 1'b0, 1'b0, 8'h00);
    // shorten the key below the held position, key byte 0 comes next
    plan_cfg(REG_KEY_LEN, 64'd3);
    plan_byte(8'h30, 1'b0, 1'b0, 8'h00);
    plan_byte(8'h2f, 1'b1, 1'b0, 8'h00);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_reg(directed_plan[i].reg_sel, directed_plan[i].value);
      end else begin
        send_text(directed_plan[i].text, directed_plan[i].last,
                  directed_plan[i].fixed, directed_plan[i].fixed_text);
      end
    end

    // random part: sixteen segments, four idling phases, fresh settings per segment
    for (int seg = 0; seg < 16; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int h = 0; h < 2; h++) begin
        sel = $urandom_range(7);
        if (sel == 0) kv = '0;
        else if (sel == 1) kv = '1;
        else kv = {$urandom, $urandom};
        write_reg((h == 0) ? REG_KEY_LOW : REG_KEY_HIGH, kv);
      end
      sel = $urandom_range(9);
      if (sel == 0) len_v = 5'd0;
      else if (sel == 1) len_v = 5'($urandom_range(31, 17));
      else if (sel == 2) len_v = 5'd16;
      else len_v = 5'($urandom_range(16, 1));
      write_reg(REG_KEY_LEN, 64'(len_v));
      write_reg(REG_DIR, 64'($urandom_range(1)));
      for (int n = 0; n < 32; n++) begin
        // half the bytes are drawn from 33 to 122, the span that holds the classes that get rotated
        if ($urandom_range(1) == 0) b = 8'($urandom_range(255));
        else b = 8'($urandom_range(122, 33));
        send_text(b, ($urandom_range(7) == 0), 1'b0, 8'h00);
      end
    end

    push <= 1'b0;
    while (pending_text_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
